FILE: sv/ptft_pkg.sv
// shared constants for the pan/tilt face tracker: widths, register indexes,
// reset values and angle limits in Q8.8 degrees
// no dependencies
`default_nettype none

package ptft_pkg;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 3'd5;

    // field widths fixed by the interface
    localparam int ANGLE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int DZ_W     = 10;
    localparam int STEP_W   = 16;
    localparam int LOSTO_W  = 16;

    // parameter defaults
    localparam int COORD_BITS_DEF = 10;
    localparam int LOST_BITS_DEF  = 16;

    // angles in Q8.8 degrees
    localparam logic [ANGLE_W-1:0] ANGLE_HOME = 16'd23040;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 16'd46080;

    // register reset values
    localparam int                 CENTER_X_RST  = 160;
    localparam int                 CENTER_Y_RST  = 120;
    localparam logic [DZ_W-1:0]    DEAD_ZONE_RST = 10'd10;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd205;
    localparam logic [STEP_W-1:0]  MAX_STEP_RST  = 16'd1280;

endpackage

`default_nettype wire

FILE: sv/pan_tilt_face_tracker.sv
// pan/tilt face tracker: a request passes the input register, then the result
// register; one request per cycle sustained,
// limited only by the output stall, since the next angles need just the
// single multiply-and-clamp pass per axis between the two registers
// synchronous active-low reset: angles home to 90 degrees, lost count and
// tracking cleared, configuration registers back to their defaults
`default_nettype none

module pan_tilt_face_tracker #(
    parameter int COORD_BITS = ptft_pkg::COORD_BITS_DEF,
    parameter int LOST_BITS  = ptft_pkg::LOST_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [ptft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ptft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // frame requests
    input  wire logic                            i_valid,
    output      logic                            o_stall,
    input  wire logic                            i_face_present,
    input  wire logic [COORD_BITS-1:0]           i_box_left,
    input  wire logic [COORD_BITS-1:0]           i_box_top,
    input  wire logic [COORD_BITS-1:0]           i_box_width,
    input  wire logic [COORD_BITS-1:0]           i_box_height,
    // results
    output      logic                            o_valid,
    input  wire logic                            i_stall,
    output      logic [ptft_pkg::ANGLE_W-1:0]    o_pan_angle,
    output      logic [ptft_pkg::ANGLE_W-1:0]    o_tilt_angle,
    output      logic                            o_moved,
    output      logic                            o_tracking_active,
    output      logic [ptft_pkg::LOSTO_W-1:0]    o_frames_lost
);
    import ptft_pkg::*;

    localparam int ERR_W  = COORD_BITS + 2;
    localparam int PROD_W = ERR_W + GAIN_W + 1;
    localparam int CMP_W  = (ERR_W > DZ_W) ? ERR_W : DZ_W;
    localparam logic [LOST_BITS-1:0] LOST_FULL = '1;

    // configuration registers
    logic [COORD_BITS-1:0] r_center_x, r_center_y;
    logic [DZ_W-1:0]       r_dead_zone;
    logic [GAIN_W-1:0]     r_pan_gain, r_tilt_gain;
    logic [STEP_W-1:0]     r_max_step;

    // input register
    logic                  r_in_valid;
    logic                  r_face;
    logic [COORD_BITS-1:0] r_left, r_top, r_width, r_height;

    // tracker state
    logic [ANGLE_W-1:0]    r_pan, r_tilt, n_pan, n_tilt;
    logic [LOST_BITS-1:0]  r_lost, n_lost;
    logic                  r_tracking, n_tracking;

    // result register
    logic                  r_out_valid;
    logic [ANGLE_W-1:0]    r_out_pan, r_out_tilt;
    logic                  r_out_moved, r_out_tracking;
    logic [LOST_BITS-1:0]  r_out_lost;

    logic                  in_take, advance, n_moved;
    logic signed [ERR_W-1:0] err_x, err_y;
    logic [ERR_W-1:0]      abs_x, abs_y;
    logic                  still;

    // one proportional step on one axis, clamped per frame and to 0..180 degrees
    function automatic logic [ANGLE_W-1:0] f_move(
        input logic [ANGLE_W-1:0]  angle,
        input logic signed [ERR_W-1:0] err,
        input logic [GAIN_W-1:0]   gain,
        input logic [STEP_W-1:0]   max_step
    );
        logic signed [PROD_W-1:0] prod, step, lim, sum;
        prod = $signed(PROD_W'(err)) * $signed(PROD_W'({1'b0, gain}));
        // floor of the negated product over 16
        step = (-prod) >>> 4;
        lim  = $signed(PROD_W'({1'b0, max_step}));
        if (step > lim) begin
            step = lim;
        end
        if (step < -lim) begin
            step = -lim;
        end
        sum = $signed(PROD_W'({1'b0, angle})) + step;
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed(PROD_W'({1'b0, ANGLE_MAX}))) begin
            sum = $signed(PROD_W'({1'b0, ANGLE_MAX}));
        end
        return ANGLE_W'(sum);
    endfunction

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // box centre error against the image centre
    always_comb begin
        err_x = $signed(ERR_W'(r_left)) + $signed(ERR_W'(r_width >> 1))
                - $signed(ERR_W'(r_center_x));
        err_y = $signed(ERR_W'(r_top)) + $signed(ERR_W'(r_height >> 1))
                - $signed(ERR_W'(r_center_y));
        abs_x = err_x[ERR_W-1] ? ERR_W'(-err_x) : ERR_W'(err_x);
        abs_y = err_y[ERR_W-1] ? ERR_W'(-err_y) : ERR_W'(err_y);
        still = (CMP_W'(abs_x) < CMP_W'(r_dead_zone))
                && (CMP_W'(abs_y) < CMP_W'(r_dead_zone));
    end

    always_comb begin
        n_pan      = r_pan;
        n_tilt     = r_tilt;
        n_lost     = r_lost;
        n_tracking = r_tracking;
        n_moved    = 1'b0;
        if (!r_face) begin
            if (r_lost != LOST_FULL) begin
                n_lost = r_lost + LOST_BITS'(1);
            end
            n_tracking = 1'b0;
        end else begin
            n_lost     = '0;
            n_tracking = 1'b1;
            if (!still) begin
                n_pan   = f_move(r_pan, err_x, r_pan_gain, r_max_step);
                n_tilt  = f_move(r_tilt, err_y, r_tilt_gain, r_max_step);
                n_moved = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= COORD_BITS'(CENTER_X_RST);
            r_center_y  <= COORD_BITS'(CENTER_Y_RST);
            r_dead_zone <= DEAD_ZONE_RST;
            r_pan_gain  <= GAIN_RST;
            r_tilt_gain <= GAIN_RST;
            r_max_step  <= MAX_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:  r_center_x  <= i_cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:  r_center_y  <= i_cfg_data[COORD_BITS-1:0];
                REG_DEAD_ZONE: r_dead_zone <= i_cfg_data[DZ_W-1:0];
                REG_PAN_GAIN:  r_pan_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_TILT_GAIN: r_tilt_gain <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_STEP:  r_max_step  <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pan       <= ANGLE_HOME;
            r_tilt      <= ANGLE_HOME;
            r_lost      <= '0;
            r_tracking  <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_pan       <= n_pan;
                r_tilt      <= n_tilt;
                r_lost      <= n_lost;
                r_tracking  <= n_tracking;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_face   <= i_face_present;
            r_left   <= i_box_left;
            r_top    <= i_box_top;
            r_width  <= i_box_width;
            r_height <= i_box_height;
        end
        if (advance) begin
            r_out_pan      <= n_pan;
            r_out_tilt     <= n_tilt;
            r_out_moved    <= n_moved;
            r_out_tracking <= n_tracking;
            r_out_lost     <= n_lost;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_pan_angle       = r_out_pan;
    assign o_tilt_angle      = r_out_tilt;
    assign o_moved           = r_out_moved;
    assign o_tracking_active = r_out_tracking;
    assign o_frames_lost     = LOSTO_W'(r_out_lost);

    a_moved_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_moved |-> r_out_tracking)
        else $error("move reported without tracking");

    a_track_clears_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_tracking |-> r_out_lost == '0)
        else $error("lost count not cleared while tracking");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pan <= ANGLE_MAX && r_tilt <= ANGLE_MAX)
        else $error("angle beyond 180 degrees");

    a_still_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !n_moved |=> r_pan == $past(r_pan) && r_tilt == $past(r_tilt))
        else $error("angles changed without a move");

endmodule

`default_nettype wire

FILE: tb/sv/tb_pan_tilt_face_tracker.sv
// testbench for the pan/tilt face tracker: frame requests with random pacing and
// output stalls, each result checked against an in-bench tracking predictor
// depends on ptft_pkg and pan_tilt_face_tracker
`timescale 1ns / 100ps

module tb_pan_tilt_face_tracker;
    import ptft_pkg::*;

    localparam int          COORD_W    = COORD_BITS_DEF;
    localparam int          COORD_TOP  = (1 << COORD_W) - 1;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned LOST_RUN   = 40;
    localparam int unsigned DRAIN_MAX  = 20000;

    // indexes past the last register, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

    typedef struct packed {
        logic               face;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } frame_req_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pan;
        logic [ANGLE_W-1:0] tilt;
        logic               moved;
        logic               tracking;
        logic [LOSTO_W-1:0] lost;
    } servo_cmd_t;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx         = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  i_valid           = 1'b0;
    logic                  o_stall;
    logic                  i_face_present    = 1'b0;
    logic [COORD_W-1:0]    i_box_left        = '0;
    logic [COORD_W-1:0]    i_box_top         = '0;
    logic [COORD_W-1:0]    i_box_width       = '0;
    logic [COORD_W-1:0]    i_box_height      = '0;
    logic                  o_valid;
    logic                  i_stall           = 1'b0;
    logic [ANGLE_W-1:0]    o_pan_angle;
    logic [ANGLE_W-1:0]    o_tilt_angle;
    logic                  o_moved;
    logic                  o_tracking_active;
    logic [LOSTO_W-1:0]    o_frames_lost;

    // predictor state and its copy of the configuration
    logic [ANGLE_W-1:0] pan_pos       = ANGLE_HOME;
    logic [ANGLE_W-1:0] tilt_pos      = ANGLE_HOME;
    logic [LOSTO_W-1:0] lost_frames   = '0;
    logic               tracking      = 1'b0;
    logic [COORD_W-1:0] cfg_cx        = COORD_W'(CENTER_X_RST);
    logic [COORD_W-1:0] cfg_cy        = COORD_W'(CENTER_Y_RST);
    logic [DZ_W-1:0]    cfg_dz        = DEAD_ZONE_RST;
    logic [GAIN_W-1:0]  cfg_pan_gain  = GAIN_RST;
    logic [GAIN_W-1:0]  cfg_tilt_gain = GAIN_RST;
    logic [STEP_W-1:0]  cfg_max_step  = MAX_STEP_RST;

    servo_cmd_t  pending_cmds[$];
    int unsigned mismatches    = 0;
    int unsigned tx_burst_left = 0;
    logic        quiet         = 1'b0;
    int unsigned holds_asked   = 0;
    int unsigned holds_given   = 0;
    int unsigned hold_left     = 0;
    logic [31:0] rx_cyc        = '0;

    pan_tilt_face_tracker u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_face_present    (i_face_present),
        .i_box_left        (i_box_left),
        .i_box_top         (i_box_top),
        .i_box_width       (i_box_width),
        .i_box_height      (i_box_height),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pan_angle       (o_pan_angle),
        .o_tilt_angle      (o_tilt_angle),
        .o_moved           (o_moved),
        .o_tracking_active (o_tracking_active),
        .o_frames_lost     (o_frames_lost)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // step is floor(-(err * gain) / 16), clamped to max_step, angle clamped to 0..180
    function automatic logic [ANGLE_W-1:0] next_angle(logic [ANGLE_W-1:0] angle,
                                                      longint err,
                                                      logic [GAIN_W-1:0] gain);
        longint step;
        longint lim;
        longint pos;
        step = (-(err * longint'(gain))) >>> 4;
        lim  = longint'(cfg_max_step);
        if (step > lim)
            step = lim;
        if (step < -lim)
            step = -lim;
        pos = longint'(angle) + step;
        if (pos < 0)
            pos = 0;
        if (pos > longint'(ANGLE_MAX))
            pos = longint'(ANGLE_MAX);
        return ANGLE_W'(pos);
    endfunction

    function automatic servo_cmd_t track_frame(frame_req_t f);
        servo_cmd_t r;
        longint     ex;
        longint     ey;
        longint     ax;
        longint     ay;
        r.moved = 1'b0;
        if (!f.face) begin
            if (lost_frames != '1)
                lost_frames++;
            tracking = 1'b0;
        end else begin
            ex = longint'(f.left) + longint'(f.width >> 1) - longint'(cfg_cx);
            ey = longint'(f.top) + longint'(f.height >> 1) - longint'(cfg_cy);
            ax = (ex < 0) ? -ex : ex;
            ay = (ey < 0) ? -ey : ey;
            lost_frames = '0;
            tracking    = 1'b1;
            if (!(ax < longint'(cfg_dz) && ay < longint'(cfg_dz))) begin
                pan_pos  = next_angle(pan_pos, ex, cfg_pan_gain);
                tilt_pos = next_angle(tilt_pos, ey, cfg_tilt_gain);
                r.moved  = 1'b1;
            end
        end
        r.pan      = pan_pos;
        r.tilt     = tilt_pos;
        r.tracking = tracking;
        r.lost     = lost_frames;
        return r;
    endfunction

    function automatic string show_cmd(servo_cmd_t c);
        return $sformatf("pan %0d tilt %0d moved %0b tracking %0b lost %0d",
                         c.pan, c.tilt, c.moved, c.tracking, c.lost);
    endfunction

    task automatic flag_error(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("error at %0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : check_results
        servo_cmd_t got;
        servo_cmd_t want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                pending_cmds.push_back(track_frame({i_face_present, i_box_left, i_box_top,
                                                    i_box_width, i_box_height}));
            if (o_valid && !i_stall) begin
                got = {o_pan_angle, o_tilt_angle, o_moved, o_tracking_active, o_frames_lost};
                if (pending_cmds.size() == 0) begin
                    flag_error({"result with no request waiting: ", show_cmd(got)});
                end else begin
                    want = pending_cmds.pop_front();
                    if (got !== want)
                        flag_error({"expected ", show_cmd(want), ", got ", show_cmd(got)});
                end
            end
        end
    end

    // output stall: a long hold when asked, otherwise a pattern that changes phase
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (holds_given != holds_asked) begin
            holds_given++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            case (rx_cyc[10:9])
                2'd0: i_stall <= 1'b0;
                2'd1: i_stall <= ($urandom_range(0, 3) == 0);
                2'd2: i_stall <= ($urandom_range(0, 9) < 6);
                default: i_stall <= (rx_cyc % 3 == 0);
            endcase
        end
    end

    task automatic send_frame(frame_req_t f);
        i_valid        <= 1'b1;
        i_face_present <= f.face;
        i_box_left     <= f.left;
        i_box_top      <= f.top;
        i_box_width    <= f.width;
        i_box_height   <= f.height;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // sender bursts of random length with random gaps between them
    task automatic pace();
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high, the caller lowers it after its last write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_CENTER_X:  cfg_cx        = data[COORD_W-1:0];
            REG_CENTER_Y:  cfg_cy        = data[COORD_W-1:0];
            REG_DEAD_ZONE: cfg_dz        = data[DZ_W-1:0];
            REG_PAN_GAIN:  cfg_pan_gain  = data;
            REG_TILT_GAIN: cfg_tilt_gain = data;
            REG_MAX_STEP:  cfg_max_step  = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] cx, logic [15:0] cy, logic [15:0] dz,
                                  logic [15:0] pg, logic [15:0] tg, logic [15:0] ms);
        wait_idle();
        cfg_write(REG_CENTER_X, cx);
        cfg_write(REG_CENTER_Y, cy);
        cfg_write(REG_DEAD_ZONE, dz);
        cfg_write(REG_PAN_GAIN, pg);
        cfg_write(REG_TILT_GAIN, tg);
        cfg_write(REG_MAX_STEP, ms);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] to_coord(int v);
        if (v < 0)
            return '0;
        if (v > COORD_TOP)
            return '1;
        return COORD_W'(v);
    endfunction

    // mostly random boxes, a good share aimed around the dead zone edge
    function automatic frame_req_t rand_frame();
        frame_req_t f;
        int         kind;
        int         lim;
        f.face   = 1'b1;
        f.left   = COORD_W'($urandom_range(0, COORD_TOP));
        f.top    = COORD_W'($urandom_range(0, COORD_TOP));
        f.width  = COORD_W'($urandom_range(0, COORD_TOP));
        f.height = COORD_W'($urandom_range(0, COORD_TOP));
        kind     = $urandom_range(0, 99);
        lim      = int'(cfg_dz) + 2;
        if (kind < 15) begin
            f.face = 1'b0;
        end else if (kind < 50) begin
            f.left = to_coord(int'(cfg_cx) + int'($urandom_range(0, 2 * lim)) - lim
                              - int'(f.width >> 1));
            f.top  = to_coord(int'(cfg_cy) + int'($urandom_range(0, 2 * lim)) - lim
                              - int'(f.height >> 1));
        end
        return f;
    endfunction

    function automatic logic [15:0] rand_word(logic [15:0] top);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return top;
            2: return 16'($urandom_range(0, 63));
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    task automatic test_default_settings();
        send_frame('{1'b0, 10'd1023, 10'd1023, 10'd1023, 10'd1023}); pace();
        send_frame('{1'b0, 10'd0, 10'd0, 10'd0, 10'd0});             pace();
        // centred box, then either side of the dead zone edge
        send_frame('{1'b1, 10'd150, 10'd110, 10'd20, 10'd20});       pace();
        send_frame('{1'b1, 10'd169, 10'd120, 10'd0, 10'd0});         pace();
        send_frame('{1'b1, 10'd170, 10'd120, 10'd0, 10'd0});         pace();
        send_frame('{1'b1, 10'd0, 10'd0, 10'd0, 10'd0});             pace();
        send_frame('{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023}); pace();
        // odd sizes round the half down
        send_frame('{1'b1, 10'd100, 10'd7, 10'd1023, 10'd511});      pace();
    endtask

    task automatic test_field_extremes();
        // zero dead zone, full gains and an oversized step: angles hit both clamps
        apply_settings(16'd0, 16'd1023, 16'd0, 16'hffff, 16'hffff, 16'hffff);
        send_frame('{1'b1, 10'd0, 10'd1023, 10'd0, 10'd0});          pace();
        send_frame('{1'b1, 10'd1023, 10'd0, 10'd1023, 10'd0});       pace();
        send_frame('{1'b1, 10'd0, 10'd1023, 10'd1, 10'd1023});       pace();
        send_frame('{1'b1, 10'd0, 10'd0, 10'd0, 10'd0});             pace();
        // widest dead zone and a zero step: moved without any change of angle
        apply_settings(16'd0, 16'd0, 16'd1023, 16'd1, 16'd1, 16'd0);
        send_frame('{1'b1, 10'd1022, 10'd0, 10'd0, 10'd0});          pace();
        send_frame('{1'b1, 10'd1023, 10'd0, 10'd0, 10'd0});          pace();
        send_frame('{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023}); pace();
    endtask

    task automatic test_unmapped_registers();
        wait_idle();
        cfg_write(REG_UNMAPPED_A, 16'hffff);
        cfg_write(REG_UNMAPPED_B, 16'h0000);
        cfg_write(REG_UNMAPPED_B, 16'hffff);
        cfg_write(REG_UNMAPPED_A, 16'h0000);
        i_cfg_we <= 1'b0;
        send_frame('{1'b1, 10'd600, 10'd40, 10'd33, 10'd9});         pace();
        send_frame('{1'b1, 10'd0, 10'd0, 10'd0, 10'd0});             pace();
        send_frame('{1'b0, 10'd5, 10'd5, 10'd5, 10'd5});             pace();
    endtask

    task automatic test_lost_count();
        wait_idle();
        quiet = 1'b1;
        // a long run of empty frames back to back, then a face clears the count
        repeat (LOST_RUN)
            send_frame('{1'b0, COORD_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom)});
        send_frame('{1'b1, 10'd300, 10'd300, 10'd10, 10'd10});
        send_frame('{1'b0, 10'd0, 10'd0, 10'd0, 10'd0});
        wait_idle();
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        wait_idle();
        holds_asked++;
        // the sender keeps offering while the output is held, so the input stalls
        repeat (40)
            send_frame(rand_frame());
        wait_idle();
    endtask

    task automatic test_random_tracking(int unsigned phases, int unsigned per_phase);
        for (int unsigned p = 0; p < phases; p++) begin
            case (p % 8)
                0: apply_settings(16'(CENTER_X_RST), 16'(CENTER_Y_RST), 16'(DEAD_ZONE_RST),
                                  GAIN_RST, GAIN_RST, MAX_STEP_RST);
                1: apply_settings(rand_word(16'd1023), rand_word(16'd1023), 16'd0,
                                  rand_word(16'hffff), rand_word(16'hffff), 16'd2000);
                2: apply_settings(rand_word(16'd1023), rand_word(16'd1023), 16'd1023,
                                  16'hffff, 16'hffff, 16'd46080);
                3: apply_settings(16'd512, 16'd384, 16'd4, 16'hffff, 16'hffff, 16'hffff);
                4: apply_settings(rand_word(16'd1023), rand_word(16'd1023), 16'd20,
                                  16'd0, 16'd0, 16'd0);
                // upper bits of the narrow registers must be dropped
                5: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom));
                default: apply_settings(rand_word(16'd1023), rand_word(16'd1023),
                                        rand_word(16'd64), rand_word(16'hffff),
                                        rand_word(16'hffff), rand_word(16'd46080));
            endcase
            for (int unsigned i = 0; i < per_phase; i++) begin
                send_frame(rand_frame());
                pace();
            end
        end
    endtask

    initial begin
        int unsigned waited;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_settings();
        test_field_extremes();
        test_unmapped_registers();
        test_lost_count();
        test_backpressure();
        test_random_tracking(8, 194);
        i_valid <= 1'b0;
        waited = 0;
        while (pending_cmds.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_cmds.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_cmds.size()));
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
